FILE: sv/abssv_pkg.sv
`default_nettype none

package abssv_pkg;

  localparam int SPEED_BITS_DEF = 8;
  localparam int SLIP_SCALE     = 100;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_RESUME_SPEED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEDAL_STEPS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLIP_RELEASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLIP_APPLY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ABS_DECEL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_STEP = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_APPLY_STEP   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_STEP    = 3'd7;

  localparam logic [7:0] KEY_MANUAL_UC = 8'h42;
  localparam logic [7:0] KEY_MANUAL_LC = 8'h62;
  localparam logic [7:0] KEY_ABS_UC    = 8'h48;
  localparam logic [7:0] KEY_ABS_LC    = 8'h68;
  localparam logic [7:0] KEY_RESUME_UC = 8'h43;
  localparam logic [7:0] KEY_RESUME_LC = 8'h63;

  localparam logic FUNC_KEY  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_MANUAL = 2'd1;
  localparam logic [1:0] MODE_ABS    = 2'd2;

  localparam logic [1:0] VALVE_NONE    = 2'd0;
  localparam logic [1:0] VALVE_RELEASE = 2'd1;
  localparam logic [1:0] VALVE_APPLY   = 2'd2;
  localparam logic [1:0] VALVE_HOLD    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [7:0] resume_speed;
    logic [3:0] pedal_steps;
    logic [6:0] slip_release_pct;
    logic [6:0] slip_apply_pct;
    logic [7:0] abs_vehicle_decel;
    logic [7:0] release_step;
    logic [7:0] apply_step;
    logic [7:0] hold_step;
  } cfg_t;

  typedef struct packed {
    logic       vehicle_stopped;
    logic       episode_end;
    logic       braking_active;
    logic [1:0] brake_mode_out;
    logic [1:0] valve_action;
    logic [7:0] wheel_speed_out;
    logic [7:0] vehicle_speed_out;
  } res_t;

endpackage

`default_nettype wire

FILE: sv/abssv_div.sv
`default_nettype none

module abssv_div import abssv_pkg::*; #(
  parameter int NUM_W = 15,
  parameter int DEN_W = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  busy_o,
  output logic [NUM_W-1:0]      quo_o
);

  localparam int CW = $clog2(NUM_W);

  logic             busy_q, busy_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    rem_sh  = {rem_q, quo_q[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (!rem_sub[DEN_W]) begin
        rem_d = rem_sub[DEN_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DEN_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(NUM_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

FILE: sv/abssv_core.sv
`default_nettype none

module abssv_core import abssv_pkg::*; #(
  parameter int SPEED_BITS = SPEED_BITS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       in_func_i,
  input  wire logic [7:0] in_key_i,
  output logic            res_valid_o,
  input  wire logic       res_ready_i,
  output res_t            res_o
);

  localparam int SB    = SPEED_BITS;
  localparam int AW    = ((SB > 8) ? SB : 8) + 2;
  localparam int NUM_W = SB + 7;
  localparam int SpeedMax = (1 << SB) - 1;
  localparam logic [SB-1:0] SpeedMaxV = '1;
  localparam logic [SB-1:0] SpeedRst  = SB'((100 > SpeedMax) ? SpeedMax : 100);

  state_e state_q, state_d;

  logic [SB-1:0] v_q, v_d;
  logic [SB-1:0] w_q, w_d;
  logic [3:0]    pedal_q, pedal_d;
  logic [1:0]    mode_q, mode_d;
  logic [1:0]    valve_q, valve_d;
  logic          ended_q, ended_d;
  logic          neg_q, neg_d;
  logic          func_q;
  logic [7:0]    key_q;

  logic                 was_active;
  logic signed [AW-1:0] v_s, w_s, v_new, mag, w_new;
  logic                 div_start, div_busy;
  logic [NUM_W-1:0]     div_num, quo;
  logic [SB-1:0]        div_den;
  logic                 slip_gt, slip_lt;

  abssv_div #(
    .NUM_W(NUM_W),
    .DEN_W(SB)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .quo_o  (quo)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_CALC;
      ST_CALC: state_d = div_start ? ST_DIV : ST_OUT;
      ST_DIV:  if (!div_busy) state_d = ST_FIN;
      ST_FIN:  state_d = ST_OUT;
      ST_OUT:  if (res_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    res_valid_o = (state_q == ST_OUT);
  end

  always_comb begin
    v_d        = v_q;
    w_d        = w_q;
    pedal_d    = pedal_q;
    mode_d     = mode_q;
    valve_d    = valve_q;
    ended_d    = ended_q;
    neg_d      = neg_q;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    was_active = (pedal_q != '0) && (v_q != '0);
    v_s        = $signed(AW'(v_q));
    w_s        = $signed(AW'(w_q));
    v_new      = v_s - $signed(AW'(cfg_i.abs_vehicle_decel));
    mag        = '0;
    w_new      = w_s;
    slip_gt    = !neg_q && (quo > NUM_W'(cfg_i.slip_release_pct));
    slip_lt    = (neg_q && (quo != '0)) || (quo < NUM_W'(cfg_i.slip_apply_pct));

    case (state_q)
      ST_CALC: begin
        valve_d = VALVE_NONE;
        ended_d = 1'b0;
        if (func_q == FUNC_KEY) begin
          if (key_q inside {KEY_MANUAL_UC, KEY_MANUAL_LC, KEY_ABS_UC, KEY_ABS_LC}) begin
            mode_d  = (key_q inside {KEY_MANUAL_UC, KEY_MANUAL_LC}) ? MODE_MANUAL : MODE_ABS;
            pedal_d = cfg_i.pedal_steps;
            if (!was_active) begin
              w_d = v_q;
            end
          end else if (key_q inside {KEY_RESUME_UC, KEY_RESUME_LC}) begin
            v_d     = (AW'(cfg_i.resume_speed) > AW'(SpeedMaxV)) ? SpeedMaxV
                                                                   : SB'(cfg_i.resume_speed);
            pedal_d = '0;
            ended_d = was_active;
          end
        end else if (was_active) begin
          pedal_d = pedal_q - 4'd1;
          case (mode_q)
            MODE_ABS: begin
              if (v_new <= 0) begin
                v_d = '0;
                w_d = '0;
              end else begin
                v_d       = v_new[SB-1:0];
                neg_d     = v_new < w_s;
                mag       = (v_new < w_s) ? (w_s - v_new) : (v_new - w_s);
                div_start = 1'b1;
                div_num   = NUM_W'(mag[SB-1:0]) * NUM_W'(SLIP_SCALE);
                div_den   = v_new[SB-1:0];
              end
            end
            MODE_MANUAL: begin
              v_d = v_q - 1'b1;
              w_d = v_q - 1'b1;
            end
            default: begin
              if (w_q > v_q) begin
                w_d = v_q;
              end
            end
          endcase
          ended_d = !((pedal_d != '0) && (v_d != '0));
        end
      end
      ST_FIN: begin
        if (slip_gt) begin
          valve_d = VALVE_RELEASE;
          w_new   = w_s + $signed(AW'(cfg_i.release_step));
        end else if (slip_lt) begin
          valve_d = VALVE_APPLY;
          w_new   = w_s - $signed(AW'(cfg_i.apply_step));
        end else begin
          valve_d = VALVE_HOLD;
          w_new   = w_s - $signed(AW'(cfg_i.hold_step));
        end
        if (w_new > v_s) begin
          w_d = v_q;
        end else if (w_new < 0) begin
          w_d = '0;
        end else begin
          w_d = w_new[SB-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      v_q     <= SpeedRst;
      w_q     <= SpeedRst;
      pedal_q <= '0;
      mode_q  <= MODE_NONE;
      valve_q <= VALVE_NONE;
      ended_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v_q     <= v_d;
      w_q     <= w_d;
      pedal_q <= pedal_d;
      mode_q  <= mode_d;
      valve_q <= valve_d;
      ended_q <= ended_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    if (in_valid_i && in_ready_o) begin
      func_q <= in_func_i;
      key_q  <= in_key_i;
    end
  end

  always_comb begin
    res_o.vehicle_speed_out = 8'(v_q);
    res_o.wheel_speed_out   = 8'(w_q);
    res_o.valve_action      = valve_q;
    res_o.brake_mode_out    = mode_q;
    res_o.braking_active    = (pedal_q != '0) && (v_q != '0);
    res_o.episode_end       = ended_q;
    res_o.vehicle_stopped   = (v_q == '0);
  end

endmodule

`default_nettype wire

FILE: sv/abs_slip_valve_brake_controller.sv
// Channel   Dir  Signals                 Contents
// s_axis    in   tvalid/tready/tdata/tuser  tuser: func; tdata: key
// m_axis    out  tvalid/tready/tdata/tlast  tlast: episode_end; tdata: status
// cfg       in   cfg_we_i/cfg_idx_i/cfg_data_i  register writes, no wait
//
// Key beats, manual and idle ticks, and ABS ticks that stop the vehicle pass
// from ST_CALC straight to ST_OUT, then into the output register.
// An active ABS tick also passes through ST_DIV and ST_FIN on the way; the serial
// slip divider retires one quotient bit per cycle over SPEED_BITS + 7 bits.
// Reset is asynchronous, active low; speeds come up at 100, saturated to the width.
// A result parks in the output register; the next beat is taken while it waits,
// and a stalled m_axis holds the sequencer in its final state.
`default_nettype none

module abs_slip_valve_brake_controller import abssv_pkg::*; #(
  parameter int SPEED_BITS = SPEED_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,  // [7:0] key
  input  wire logic                  s_axis_tuser,  // [0] func
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [7:0] vehicle_speed_out, [15:8] wheel_speed_out, [17:16] valve_action,
  // [19:18] brake_mode_out, [20] braking_active, [21] vehicle_stopped, [23:22] zero
  output logic [23:0]                m_axis_tdata,
  output logic                       m_axis_tlast,  // episode_end
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q;
  res_t core_res;
  res_t out_q;
  logic out_valid_q;
  logic core_valid;
  logic core_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.resume_speed      <= 8'd100;
      cfg_q.pedal_steps       <= 4'd5;
      cfg_q.slip_release_pct  <= 7'd20;
      cfg_q.slip_apply_pct    <= 7'd10;
      cfg_q.abs_vehicle_decel <= 8'd4;
      cfg_q.release_step      <= 8'd8;
      cfg_q.apply_step        <= 8'd12;
      cfg_q.hold_step         <= 8'd6;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RESUME_SPEED: cfg_q.resume_speed      <= cfg_data_i;
        CFG_PEDAL_STEPS:  cfg_q.pedal_steps       <= cfg_data_i[3:0];
        CFG_SLIP_RELEASE: cfg_q.slip_release_pct  <= cfg_data_i[6:0];
        CFG_SLIP_APPLY:   cfg_q.slip_apply_pct    <= cfg_data_i[6:0];
        CFG_ABS_DECEL:    cfg_q.abs_vehicle_decel <= cfg_data_i;
        CFG_RELEASE_STEP: cfg_q.release_step      <= cfg_data_i;
        CFG_APPLY_STEP:   cfg_q.apply_step        <= cfg_data_i;
        CFG_HOLD_STEP:    cfg_q.hold_step         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  abssv_core #(
    .SPEED_BITS(SPEED_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_func_i  (s_axis_tuser),
    .in_key_i   (s_axis_tdata),
    .res_valid_o(core_valid),
    .res_ready_i(core_ready),
    .res_o      (core_res)
  );

  assign core_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_ready) begin
      out_valid_q <= core_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_ready && core_valid) begin
      out_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.episode_end;
  assign m_axis_tdata  = {2'b00, out_q.vehicle_stopped, out_q.braking_active,
                          out_q.brake_mode_out, out_q.valve_action,
                          out_q.wheel_speed_out, out_q.vehicle_speed_out};

endmodule

`default_nettype wire
